// ===== rtl/modexp_pkg.sv =====
// Shared types and constants for the modular exponentiation block.
// Used by modexp_mulmod and modular_exponentiation; depends on nothing.
package modexp_pkg;

    localparam int DATA_WIDTH      = 32;
    localparam int CFG_INDEX_WIDTH = 8;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MODULUS  = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_EXPONENT = 8'd1;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_REDUCE = 6'b000010,
        ST_STEP   = 6'b000100,
        ST_MULT   = 6'b001000,
        ST_SQUARE = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    // Status of the shared modular multiplier as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } mm_status_t;

endpackage

// ===== rtl/modular_exponentiation.sv =====
// Top level of the modular exponentiation block: sequencer, key registers, output register.
// Depends on modexp_pkg and modexp_mulmod.
//
// Computes base_value ^ exponent mod modulus by right-to-left square-and-multiply, all
// on one bit-serial modular multiplier. An item first spends one product reducing the
// base, then, for each exponent bit up to the highest set one, one product for a set bit
// and one squaring (the squaring after the highest set bit is skipped). A zero exponent
// returns 1 without any product. s_ready is high only while no item is in progress; a
// finished result sits in an output register, so the next transaction is taken while
// the previous result waits on m_ready. A zero modulus acts as 2^OPERAND_WIDTH.
// Modulus and exponent may be written only while the block is idle.
module modular_exponentiation #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [modexp_pkg::DATA_WIDTH-1:0]      s_base_value,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [modexp_pkg::DATA_WIDTH-1:0]      m_power_result,
    input  logic                                   cfg_wr_en,
    input  logic [modexp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [modexp_pkg::DATA_WIDTH-1:0]      cfg_data
);

    localparam int W = OPERAND_WIDTH;

    modexp_pkg::state_t state_reg, state_next;

    logic [W-1:0] modulus_reg, modulus_next;
    logic [W-1:0] exponent_reg, exponent_next;
    logic [W-1:0] acc_reg, acc_next;
    logic [W-1:0] sq_reg, sq_next;
    logic [W-1:0] e_reg, e_next;
    logic         m_valid_reg, m_valid_next;
    logic [modexp_pkg::DATA_WIDTH-1:0] m_data_reg, m_data_next;

    logic [W:0]   modulus_eff;
    logic [W-1:0] one_mod;
    logic         mm_start;
    logic [W-1:0] mm_a;
    logic [W-1:0] mm_b;
    logic [W-1:0] mm_result;
    modexp_pkg::mm_status_t mm_status;

    // A zero modulus stands for 2^W; one reduced by a modulus of one is zero.
    assign modulus_eff = (modulus_reg == '0) ? {1'b1, {W{1'b0}}} : {1'b0, modulus_reg};
    assign one_mod     = {{(W-1){1'b0}}, (modulus_reg != {{(W-1){1'b0}}, 1'b1})};

    modexp_mulmod #(
        .WIDTH(W)
    ) u_mulmod (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (mm_start),
        .op_a        (mm_a),
        .op_b        (mm_b),
        .modulus_eff (modulus_eff),
        .result      (mm_result),
        .status      (mm_status)
    );

    always_comb begin
        modulus_next  = modulus_reg;
        exponent_next = exponent_reg;
        if (cfg_wr_en) begin
            if (cfg_index == modexp_pkg::CFG_MODULUS) begin
                modulus_next = cfg_data[W-1:0];
            end else if (cfg_index == modexp_pkg::CFG_EXPONENT) begin
                exponent_next = cfg_data[W-1:0];
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        acc_next     = acc_reg;
        sq_next      = sq_reg;
        e_next       = e_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        mm_start     = 1'b0;
        mm_a         = '0;
        mm_b         = '0;
        unique case (state_reg)
            modexp_pkg::ST_IDLE: begin
                if (s_valid) begin
                    sq_next = s_base_value[W-1:0];
                    e_next  = exponent_reg;
                    if (exponent_reg == '0) begin
                        acc_next   = {{(W-1){1'b0}}, 1'b1};
                        state_next = modexp_pkg::ST_DONE;
                    end else begin
                        // Reduce the base once so every later operand is below the modulus.
                        acc_next   = one_mod;
                        mm_start   = 1'b1;
                        mm_a       = s_base_value[W-1:0];
                        mm_b       = one_mod;
                        state_next = modexp_pkg::ST_REDUCE;
                    end
                end
            end
            modexp_pkg::ST_REDUCE: begin
                if (mm_status.done) begin
                    sq_next    = mm_result;
                    state_next = modexp_pkg::ST_STEP;
                end
            end
            modexp_pkg::ST_STEP: begin
                priority if (e_reg == '0) begin
                    state_next = modexp_pkg::ST_DONE;
                end else if (e_reg[0]) begin
                    mm_start   = 1'b1;
                    mm_a       = acc_reg;
                    mm_b       = sq_reg;
                    state_next = modexp_pkg::ST_MULT;
                end else begin
                    mm_start   = 1'b1;
                    mm_a       = sq_reg;
                    mm_b       = sq_reg;
                    state_next = modexp_pkg::ST_SQUARE;
                end
            end
            modexp_pkg::ST_MULT: begin
                if (mm_status.done) begin
                    // Clearing the bit sends the next step to the squaring, or to the end.
                    acc_next   = mm_result;
                    e_next     = {e_reg[W-1:1], 1'b0};
                    state_next = modexp_pkg::ST_STEP;
                end
            end
            modexp_pkg::ST_SQUARE: begin
                if (mm_status.done) begin
                    sq_next    = mm_result;
                    e_next     = {1'b0, e_reg[W-1:1]};
                    state_next = modexp_pkg::ST_STEP;
                end
            end
            modexp_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = modexp_pkg::DATA_WIDTH'(acc_reg);
                    state_next   = modexp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = modexp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= modexp_pkg::ST_IDLE;
            modulus_reg  <= {{(W-1){1'b0}}, 1'b1};
            exponent_reg <= {{(W-1){1'b0}}, 1'b1};
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            modulus_reg  <= modulus_next;
            exponent_reg <= exponent_next;
            m_valid_reg  <= m_valid_next;
        end
        acc_reg    <= acc_next;
        sq_reg     <= sq_next;
        e_reg      <= e_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready        = (state_reg == modexp_pkg::ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_power_result = m_data_reg;

    a_ready_unit_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !mm_status.busy)
        else $error("input ready while the multiplier is still busy");

    a_done_in_wait_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mm_status.done |-> (state_reg == modexp_pkg::ST_REDUCE ||
                            state_reg == modexp_pkg::ST_MULT ||
                            state_reg == modexp_pkg::ST_SQUARE))
        else $error("multiplier finished while the sequencer was not waiting");

    a_exp_nonzero_in_op: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == modexp_pkg::ST_MULT || state_reg == modexp_pkg::ST_SQUARE)
            |-> (e_reg != '0))
        else $error("product in progress with no exponent bits left");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == modexp_pkg::ST_DONE))
        else $error("result raised outside the completion state");

endmodule

// ===== rtl/modexp_mulmod.sv =====
// Bit-serial interleaved modular multiplier, one bit of the serial operand per cycle.
// Depends on modexp_pkg for the status struct.
module modexp_mulmod #(
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [WIDTH-1:0]         op_a,
    input  logic [WIDTH-1:0]         op_b,
    input  logic [WIDTH:0]           modulus_eff,
    output logic [WIDTH-1:0]         result,
    output modexp_pkg::mm_status_t   status
);

    localparam int CNT_WIDTH = $clog2(WIDTH);

    logic [WIDTH-1:0]     a_reg, a_next;
    logic [WIDTH-1:0]     b_reg, b_next;
    logic [WIDTH-1:0]     r_reg, r_next;
    logic [CNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [WIDTH+1:0] sum;
    logic [WIDTH+1:0] n1;
    logic [WIDTH+1:0] n2;
    logic [WIDTH+1:0] reduced;

    // The serial operand may be unreduced; the addend and the partial result are
    // below the modulus, so the sum stays below three times it.
    always_comb begin
        n1  = {1'b0, modulus_eff};
        n2  = {modulus_eff, 1'b0};
        sum = {1'b0, r_reg, 1'b0} + (a_reg[WIDTH-1] ? {2'b00, b_reg} : '0);
        priority if (sum >= n2) begin
            reduced = sum - n2;
        end else if (sum >= n1) begin
            reduced = sum - n1;
        end else begin
            reduced = sum;
        end
    end

    always_comb begin
        a_next    = a_reg;
        b_next    = b_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            a_next    = op_a;
            b_next    = op_b;
            r_next    = '0;
            cnt_next  = CNT_WIDTH'(WIDTH - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            a_next   = {a_reg[WIDTH-2:0], 1'b0};
            r_next   = reduced[WIDTH-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        a_reg   <= a_next;
        b_reg   <= b_next;
        r_reg   <= r_next;
        cnt_reg <= cnt_next;
    end

    assign result      = r_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("multiplier started while busy");

    a_last_bit_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && cnt_reg == '0 && !start) |=> (done_reg && !busy_reg))
        else $error("multiplier did not finish after its last bit");

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("done pulse without a preceding busy cycle");

endmodule
